// ===== src/miller_rabin_witness_test_defines.svh =====
`ifndef MILLER_RABIN_WITNESS_TEST_DEFINES_SVH
`define MILLER_RABIN_WITNESS_TEST_DEFINES_SVH

// same-cycle implication
`define MRW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mrw_pkg.sv =====
`default_nettype none
package mrw_pkg;

  localparam int unsigned WidthDefault = 64;

  typedef enum logic [3:0] {
    StIdle,
    StStrip,
    StReduce,
    StPow,
    StMulAcc,
    StMulSqr,
    StCheck,
    StLoop,
    StLoopSqr,
    StDone
  } state_e;

endpackage
`default_nettype wire

// ===== src/mrw_modmul.sv =====
`default_nettype none
`include "miller_rabin_witness_test_defines.svh"
module mrw_modmul #(
  parameter int unsigned WIDTH = mrw_pkg::WidthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] x_i,
  input  wire logic [WIDTH-1:0] y_i,
  input  wire logic [WIDTH-1:0] n_i,
  output logic                  done_o,
  output logic      [WIDTH-1:0] res_o
);
  import mrw_pkg::*;

  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy_q, busy_d;
  logic             phase_q, phase_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [WIDTH-1:0] n_q, n_d;
  logic             done_d;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   red;

  // interleaved multiply, multiplier MSB first: double then add, one per cycle
  always_comb begin
    sum = phase_q ? ({1'b0, acc_q} + {1'b0, x_q}) : {acc_q, 1'b0};
    red = (sum >= {1'b0, n_q}) ? (sum - {1'b0, n_q}) : sum;
  end

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    n_d     = n_q;
    done_d  = 1'b0;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      cnt_d   = '0;
      acc_d   = '0;
      x_d     = x_i;
      y_d     = y_i;
      n_d     = n_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        acc_d   = red[WIDTH-1:0];
        phase_d = 1'b1;
      end else begin
        if (y_q[WIDTH-1]) begin
          acc_d = red[WIDTH-1:0];
        end
        y_d     = {y_q[WIDTH-2:0], 1'b0};
        phase_d = 1'b0;
        if (cnt_q == CW'(WIDTH - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    n_q   <= n_d;
  end

  assign res_o = acc_q;

  `MRW_ASSERT_NEXT(a_start_busy, start_i, busy_q, "modmul did not start")
  `MRW_ASSERT_NOW(a_done_idle, done_o, !busy_q, "modmul done while busy")
  `MRW_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "modmul done held over two cycles")

endmodule
`default_nettype wire

// ===== src/miller_rabin_witness_test.sv =====
// Miller-Rabin witness test, one candidate and witness per transfer.
// Even or unit candidates go straight to the result; odd candidates take
// bit-serial modular products, at most about 2*WIDTH of them.
// Throughput: one transfer at a time; input stalls until the result is queued.
// The shared bit-serial modular multiplier sets the rate.
// Reset (rst_ni low, asynchronous) returns to idle with no result pending.
`default_nettype none
`include "miller_rabin_witness_test_defines.svh"
module miller_rabin_witness_test #(
  parameter int unsigned WIDTH = mrw_pkg::WidthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [WIDTH-1:0] candidate_i,
  input  wire logic [WIDTH-1:0] witness_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  passes_o
);
  import mrw_pkg::*;

  localparam int unsigned TW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  state_e           state_q, state_d;
  logic [WIDTH-1:0] n_q, n_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] m_q, m_d;
  logic [TW-1:0]    t_q, t_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] base_q, base_d;
  logic             ok_q, ok_d;
  logic             out_valid_q, out_valid_d;
  logic             passes_q, passes_d;
  logic [WIDTH-1:0] nm1;
  logic [WIDTH-1:0] mm_x, mm_y, mm_res;
  logic             mm_start;
  logic             mm_done;

  assign nm1 = n_q - 1'b1;

  mrw_modmul #(.WIDTH(WIDTH)) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .n_i     (n_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    a_d         = a_q;
    m_d         = m_q;
    t_d         = t_q;
    acc_d       = acc_q;
    base_d      = base_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    passes_d    = passes_q;
    mm_start    = 1'b0;
    mm_x        = base_q;
    mm_y        = base_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          n_d = candidate_i;
          a_d = witness_i;
          m_d = candidate_i - 1'b1;
          t_d = '0;
          if (!candidate_i[0]) begin
            ok_d    = (candidate_i == WIDTH'(2));
            state_d = StDone;
          end else if (candidate_i == WIDTH'(1)) begin
            ok_d    = 1'b1;
            state_d = StDone;
          end else begin
            state_d = StStrip;
          end
        end
      end
      StStrip: begin
        if (!m_q[0]) begin
          m_d = m_q >> 1;
          t_d = t_q + 1'b1;
        end else begin
          mm_start = 1'b1;
          mm_x     = WIDTH'(1);
          mm_y     = a_q;
          state_d  = StReduce;
        end
      end
      StReduce: begin
        if (mm_done) begin
          base_d  = mm_res;
          acc_d   = WIDTH'(1);
          state_d = StPow;
        end
      end
      StPow: begin
        if (m_q == '0) begin
          state_d = StCheck;
        end else if (m_q[0]) begin
          mm_start = 1'b1;
          mm_x     = acc_q;
          mm_y     = base_q;
          state_d  = StMulAcc;
        end else begin
          mm_start = 1'b1;
          state_d  = StMulSqr;
        end
      end
      StMulAcc: begin
        if (mm_done) begin
          acc_d    = mm_res;
          mm_start = 1'b1;
          state_d  = StMulSqr;
        end
      end
      StMulSqr: begin
        if (mm_done) begin
          base_d  = mm_res;
          m_d     = m_q >> 1;
          state_d = StPow;
        end
      end
      StCheck: begin
        if (acc_q == WIDTH'(1) || acc_q == nm1) begin
          ok_d    = 1'b1;
          state_d = StDone;
        end else begin
          t_d     = t_q - 1'b1;
          state_d = StLoop;
        end
      end
      StLoop: begin
        if (t_q == '0) begin
          ok_d    = 1'b0;
          state_d = StDone;
        end else begin
          mm_start = 1'b1;
          mm_x     = acc_q;
          mm_y     = acc_q;
          state_d  = StLoopSqr;
        end
      end
      StLoopSqr: begin
        if (mm_done) begin
          acc_d = mm_res;
          if (mm_res == nm1) begin
            ok_d    = 1'b1;
            state_d = StDone;
          end else begin
            t_d     = t_q - 1'b1;
            state_d = StLoop;
          end
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          passes_d    = ok_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    a_q      <= a_d;
    m_q      <= m_d;
    t_q      <= t_d;
    acc_q    <= acc_d;
    base_q   <= base_d;
    ok_q     <= ok_d;
    passes_q <= passes_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign passes_o    = passes_q;

  `MRW_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != StIdle,
    "transfer accepted but sequencer stayed idle")
  `MRW_ASSERT_NOW(a_done_in_wait,
    mm_done,
    state_q == StReduce || state_q == StMulAcc || state_q == StMulSqr ||
    state_q == StLoopSqr,
    "product finished outside a wait state")
  `MRW_ASSERT_NOW(a_start_in_idle_mul, mm_start && state_q != StMulAcc, !mm_done,
    "product started while another finished")

endmodule
`default_nettype wire
